>>> rtl/prt_pkg.sv
`timescale 1ns / 1ps

package prt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEF_W          = 16;
    localparam int ROW_W           = 3 * COEF_W;
    localparam int SHIFT_W         = 32;
    localparam int FRAC_SHIFT      = 14;
    localparam int ROUND_BIAS      = 1 << (FRAC_SHIFT - 1);

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_IDX_LO = 3;

    localparam logic [ROW_W-1:0] ROW_X_RST = ROW_W'(64'd16384);
    localparam logic [ROW_W-1:0] ROW_Y_RST = ROW_W'(64'd16384 << 16);
    localparam logic [ROW_W-1:0] ROW_Z_RST = ROW_W'(64'd16384 << 32);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X   = 3'd0,
        REG_ROW_Y   = 3'd1,
        REG_ROW_Z   = 3'd2,
        REG_SHIFT_X = 3'd3,
        REG_SHIFT_Y = 3'd4,
        REG_SHIFT_Z = 3'd5
    } prt_reg_idx_t;

    // per-stage load enables of the datapath
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } prt_adv_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row_x;
        logic [ROW_W-1:0]   row_y;
        logic [ROW_W-1:0]   row_z;
        logic [SHIFT_W-1:0] shift_x;
        logic [SHIFT_W-1:0] shift_y;
        logic [SHIFT_W-1:0] shift_z;
    } prt_cfg_t;

endpackage

>>> rtl/point_rigid_transform.sv
`timescale 1ns / 1ps

// point_rigid_transform: applies a 3x4 affine transform to a stream of points.
// each point (s_in_x, s_in_y, s_in_z, signed fixed point with 16 fraction bits)
// is multiplied by a 3x3 matrix of signed q1.14 coefficients, the three products
// of each row are summed exactly, rounded half up to 16 fraction bits, offset by
// the row's translation and clamped to the coordinate range; m_saturated flags a
// clamp on any axis and m_out_last copies s_in_last. the datapath is a three-
// stage pipeline (multiply, sum and round, translate and clamp), so one point is
// taken per cycle while the output is not stalled, its result registered in each
// stage in turn; a stalled output fills the stages before s_ready drops, and empty
// stages collapse so that no bubble is kept. registers sit on a 64-bit apb port at
// byte address 8*i: rotation_row_x/y/z (0x00, 0x08, 0x10; column 0 in bits 15:0,
// column 1 in 31:16, column 2 in 47:32; identity at reset) and shift_x/y/z
// (0x18, 0x20, 0x28; zero at reset). registers are only to be written while the
// pipeline is empty.

module point_rigid_transform #(
    parameter int COORD_WIDTH = prt_pkg::COORD_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // apb configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [prt_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [prt_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,

    // point input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [COORD_WIDTH-1:0]         s_in_x,
    input  logic [COORD_WIDTH-1:0]         s_in_y,
    input  logic [COORD_WIDTH-1:0]         s_in_z,
    input  logic                           s_in_last,

    // transformed point output
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [COORD_WIDTH-1:0]         m_out_x,
    output logic [COORD_WIDTH-1:0]         m_out_y,
    output logic [COORD_WIDTH-1:0]         m_out_z,
    output logic                           m_out_last,
    output logic                           m_saturated
);
    import prt_pkg::*;

    localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    prt_cfg_t cfg;
    prt_adv_t adv;

    // stage valid bits, stage 3 is the output register
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic last1_reg, last2_reg, last3_reg;
    logic sat_x, sat_y, sat_z;

    assign pready = 1'b1;

    prt_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // a stage loads when it is empty or its contents move on this cycle
    assign adv.ld3 = !v3_reg || m_ready;
    assign adv.ld2 = !v2_reg || adv.ld3;
    assign adv.ld1 = !v1_reg || adv.ld2;
    assign s_ready = adv.ld1;

    assign v1_next = adv.ld1 ? s_valid : v1_reg;
    assign v2_next = adv.ld2 ? v1_reg  : v2_reg;
    assign v3_next = adv.ld3 ? v2_reg  : v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // last flag rides alongside the datapath
    always_ff @(posedge aclk) begin
        if (adv.ld1) begin
            last1_reg <= s_in_last;
        end
        if (adv.ld2) begin
            last2_reg <= last1_reg;
        end
        if (adv.ld3) begin
            last3_reg <= last2_reg;
        end
    end

    // one row unit per output axis
    prt_row #(.COORD_WIDTH(COORD_WIDTH)) u_row_x (
        .aclk     (aclk),
        .adv      (adv),
        .in_x     (s_in_x),
        .in_y     (s_in_y),
        .in_z     (s_in_z),
        .coef_row (cfg.row_x),
        .shift    (cfg.shift_x),
        .coord    (m_out_x),
        .sat      (sat_x)
    );

    prt_row #(.COORD_WIDTH(COORD_WIDTH)) u_row_y (
        .aclk     (aclk),
        .adv      (adv),
        .in_x     (s_in_x),
        .in_y     (s_in_y),
        .in_z     (s_in_z),
        .coef_row (cfg.row_y),
        .shift    (cfg.shift_y),
        .coord    (m_out_y),
        .sat      (sat_y)
    );

    prt_row #(.COORD_WIDTH(COORD_WIDTH)) u_row_z (
        .aclk     (aclk),
        .adv      (adv),
        .in_x     (s_in_x),
        .in_y     (s_in_y),
        .in_z     (s_in_z),
        .coef_row (cfg.row_z),
        .shift    (cfg.shift_z),
        .coord    (m_out_z),
        .sat      (sat_z)
    );

    assign m_valid     = v3_reg;
    assign m_out_last  = last3_reg;
    assign m_saturated = sat_x || sat_y || sat_z;

    // a free output slot always lets a new request in
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("s_ready low while output slot is free");

    // a stage-2 point moves into the output slot when it opens
    a_stage2_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && adv.ld3) |=> m_valid)
        else $error("point lost between stage 2 and output");

    // a clamp flag means some axis sits at a range limit
    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_out_x == C_MAX || m_out_x == C_MIN ||
             m_out_y == C_MAX || m_out_y == C_MIN ||
             m_out_z == C_MAX || m_out_z == C_MIN))
        else $error("saturated set with no coordinate at a limit");

endmodule

>>> rtl/prt_cfg.sv
`timescale 1ns / 1ps

module prt_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [prt_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [prt_pkg::CFG_DATA_W-1:0] prdata,
    output prt_pkg::prt_cfg_t             cfg
);
    import prt_pkg::*;

    prt_cfg_t     cfg_reg;
    prt_cfg_t     cfg_next;
    prt_reg_idx_t idx;
    logic         wr_en;

    assign idx   = prt_reg_idx_t'(paddr[CFG_IDX_LO +: CFG_IDX_W]);
    assign wr_en = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_ROW_X:   cfg_next.row_x   = pwdata[ROW_W-1:0];
                REG_ROW_Y:   cfg_next.row_y   = pwdata[ROW_W-1:0];
                REG_ROW_Z:   cfg_next.row_z   = pwdata[ROW_W-1:0];
                REG_SHIFT_X: cfg_next.shift_x = pwdata[SHIFT_W-1:0];
                REG_SHIFT_Y: cfg_next.shift_y = pwdata[SHIFT_W-1:0];
                REG_SHIFT_Z: cfg_next.shift_z = pwdata[SHIFT_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_x   <= ROW_X_RST;
            cfg_reg.row_y   <= ROW_Y_RST;
            cfg_reg.row_z   <= ROW_Z_RST;
            cfg_reg.shift_x <= '0;
            cfg_reg.shift_y <= '0;
            cfg_reg.shift_z <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_ROW_X:   prdata = CFG_DATA_W'(cfg_reg.row_x);
            REG_ROW_Y:   prdata = CFG_DATA_W'(cfg_reg.row_y);
            REG_ROW_Z:   prdata = CFG_DATA_W'(cfg_reg.row_z);
            REG_SHIFT_X: prdata = CFG_DATA_W'(cfg_reg.shift_x);
            REG_SHIFT_Y: prdata = CFG_DATA_W'(cfg_reg.shift_y);
            REG_SHIFT_Z: prdata = CFG_DATA_W'(cfg_reg.shift_z);
            default:     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/prt_row.sv
`timescale 1ns / 1ps

module prt_row #(
    parameter int COORD_WIDTH = prt_pkg::COORD_WIDTH_DEF
) (
    input  logic                       aclk,
    input  prt_pkg::prt_adv_t          adv,
    input  logic [COORD_WIDTH-1:0]     in_x,
    input  logic [COORD_WIDTH-1:0]     in_y,
    input  logic [COORD_WIDTH-1:0]     in_z,
    input  logic [prt_pkg::ROW_W-1:0]  coef_row,
    input  logic [prt_pkg::SHIFT_W-1:0] shift,
    output logic [COORD_WIDTH-1:0]     coord,
    output logic                       sat
);
    import prt_pkg::*;

    localparam int PW = COORD_WIDTH + COEF_W;          // one product
    localparam int SW = PW + 2;                        // sum of three
    localparam int RW = SW - FRAC_SHIFT;               // back to 16 fraction bits
    localparam int TW = ((RW > SHIFT_W) ? RW : SHIFT_W) + 1;

    localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [COEF_W-1:0]      c0, c1, c2;
    logic signed [COORD_WIDTH-1:0] px, py, pz;
    logic signed [SHIFT_W-1:0]     shift_s;

    logic signed [PW-1:0] prod_next [3];
    logic signed [PW-1:0] prod_reg  [3];
    logic signed [SW-1:0] sum_next;
    logic signed [RW-1:0] rnd_next;
    logic signed [RW-1:0] rnd_reg;
    logic signed [TW-1:0] total;
    logic [TW-COORD_WIDTH:0] hi_bits;
    logic                    ovf;
    logic [COORD_WIDTH-1:0]  coord_next;
    logic [COORD_WIDTH-1:0]  coord_reg;
    logic                    sat_reg;

    assign c0      = coef_row[COEF_W-1:0];
    assign c1      = coef_row[2*COEF_W-1:COEF_W];
    assign c2      = coef_row[3*COEF_W-1:2*COEF_W];
    assign px      = in_x;
    assign py      = in_y;
    assign pz      = in_z;
    assign shift_s = shift;

    // stage 1: products
    assign prod_next[0] = px * c0;
    assign prod_next[1] = py * c1;
    assign prod_next[2] = pz * c2;

    always_ff @(posedge aclk) begin
        if (adv.ld1) begin
            prod_reg <= prod_next;
        end
    end

    // stage 2: exact sum, round half up to 16 fraction bits
    assign sum_next = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2])
                    + SW'(ROUND_BIAS);
    assign rnd_next = sum_next[SW-1:FRAC_SHIFT];

    always_ff @(posedge aclk) begin
        if (adv.ld2) begin
            rnd_reg <= rnd_next;
        end
    end

    // stage 3: translation and clamp
    assign total   = TW'(rnd_reg) + TW'(shift_s);
    assign hi_bits = total[TW-1:COORD_WIDTH-1];
    assign ovf     = !((&hi_bits) || !(|hi_bits));

    always_comb begin
        if (ovf) begin
            coord_next = total[TW-1] ? C_MIN : C_MAX;
        end else begin
            coord_next = total[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.ld3) begin
            coord_reg <= coord_next;
            sat_reg   <= ovf;
        end
    end

    assign coord = coord_reg;
    assign sat   = sat_reg;

endmodule

>>> tb/point_rigid_transform_tb.sv
`timescale 1ns / 1ps

module point_rigid_transform_tb;

    import prt_pkg::*;

    // coordinate width of the instance under test
    localparam int CW         = COORD_WIDTH_DEF;
    // pipeline depth, used for the final quiet period
    localparam int PIPE_DEPTH = 3;
    // random part: blocks of points, each under a fresh register setting
    localparam int NUM_BLOCKS = 15;
    localparam int BLOCK_LEN  = 50;
    // long receiver hold-off that backs the pipeline up into s_ready
    localparam int HOLD_OFF   = 200;
    // register indexes past the map, writes there must do nothing
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

    // one transformed point as it leaves the block
    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          last;
        logic          sat;
    } point_out_t;

    // one row of the directed plan: a register write or a point request
    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [63:0]          data;
        logic [CW-1:0]        x;
        logic [CW-1:0]        y;
        logic [CW-1:0]        z;
        logic                 last;
        logic                 typed;
        point_out_t           want;
    } plan_row_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [CW-1:0]         s_in_x    = '0;
    logic [CW-1:0]         s_in_y    = '0;
    logic [CW-1:0]         s_in_z    = '0;
    logic                  s_in_last = 1'b0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [CW-1:0]         m_out_x;
    logic [CW-1:0]         m_out_y;
    logic [CW-1:0]         m_out_z;
    logic                  m_out_last;
    logic                  m_saturated;

    // shadow copy of the transform registers
    prt_cfg_t   shadow_cfg;
    // transformed points still owed by the block, oldest first
    point_out_t owed_points[$];
    plan_row_t  directed_plan[$];

    int fail_count    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;

    point_rigid_transform #(
        .COORD_WIDTH(CW)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_x     (s_in_x),
        .s_in_y     (s_in_y),
        .s_in_z     (s_in_z),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_x    (m_out_x),
        .m_out_y    (m_out_y),
        .m_out_z    (m_out_z),
        .m_out_last (m_out_last),
        .m_saturated(m_saturated)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // one output axis: dot product of a row with the point, rounded half up
    // from 30 to 16 fraction bits, plus the translation, then clamped
    function automatic logic [CW-1:0] axis_value(input logic [ROW_W-1:0] row,
                                                 input logic [SHIFT_W-1:0] ofs,
                                                 input logic [CW-1:0] px,
                                                 input logic [CW-1:0] py,
                                                 input logic [CW-1:0] pz,
                                                 output logic clamped);
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic signed [63:0] cz;
        logic signed [63:0] vx;
        logic signed [63:0] vy;
        logic signed [63:0] vz;
        logic signed [63:0] dot;
        logic signed [63:0] total;
        logic signed [63:0] lim_hi;
        logic signed [63:0] lim_lo;
        cx = $signed(row[COEF_W-1:0]);
        cy = $signed(row[2*COEF_W-1:COEF_W]);
        cz = $signed(row[3*COEF_W-1:2*COEF_W]);
        vx = $signed(px);
        vy = $signed(py);
        vz = $signed(pz);
        dot = vx * cx + vy * cy + vz * cz;
        // arithmetic shift floors, so the bias gives ties going up
        total = (dot + 64'sd8192) >>> FRAC_SHIFT;
        total = total + 64'($signed(ofs));
        lim_hi = (64'sd1 <<< (CW - 1)) - 64'sd1;
        lim_lo = -lim_hi - 64'sd1;
        clamped = 1'b0;
        if (total > lim_hi) begin
            total = lim_hi;
            clamped = 1'b1;
        end else if (total < lim_lo) begin
            total = lim_lo;
            clamped = 1'b1;
        end
        return total[CW-1:0];
    endfunction

    function automatic point_out_t transform_point(input logic [CW-1:0] px,
                                                   input logic [CW-1:0] py,
                                                   input logic [CW-1:0] pz,
                                                   input logic lst);
        point_out_t r;
        logic       sx;
        logic       sy;
        logic       sz;
        r.x = axis_value(shadow_cfg.row_x, shadow_cfg.shift_x, px, py, pz, sx);
        r.y = axis_value(shadow_cfg.row_y, shadow_cfg.shift_y, px, py, pz, sy);
        r.z = axis_value(shadow_cfg.row_z, shadow_cfg.shift_z, px, py, pz, sz);
        r.last = lst;
        r.sat = sx | sy | sz;
        return r;
    endfunction

    // random q1.14 coefficient: full scale, unit, near rotation or anything
    function automatic logic [COEF_W-1:0] pick_coef();
        logic [COEF_W-1:0] c;
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(4))
                    0: c = 16'h8000;
                    1: c = 16'h7FFF;
                    2: c = 16'h0000;
                    3: c = 16'h4000;
                    default: c = 16'hC000;
                endcase
            end
            1: c = COEF_W'($urandom());
            default: c = COEF_W'($urandom_range(16'h8000)) - 16'h4000;
        endcase
        return c;
    endfunction

    // random translation or coordinate value, both signed q16.16
    function automatic logic [31:0] pick_fixed();
        logic [31:0] v;
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(4))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            1: v = $urandom();
            default: v = 32'($urandom_range(32'h001F_FFFF)) - 32'h0010_0000;
        endcase
        return v;
    endfunction

    task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        directed_plan.push_back(r);
    endtask

    // typed rows carry their result, the rest go through the predictor
    task automatic plan_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic [CW-1:0] z, input logic last,
                              input logic typed, input logic [CW-1:0] ex,
                              input logic [CW-1:0] ey, input logic [CW-1:0] ez,
                              input logic esat);
        plan_row_t r;
        r = '{default: '0};
        r.x = x;
        r.y = y;
        r.z = z;
        r.last = last;
        r.typed = typed;
        r.want = '{x: ex, y: ey, z: ez, last: last, sat: esat};
        directed_plan.push_back(r);
    endtask

    // apb write: setup phase, then access until pready, then back to idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(idx) << CFG_IDX_LO;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // upper bits past the register width are dropped
        case (idx)
            REG_ROW_X:   shadow_cfg.row_x = data[ROW_W-1:0];
            REG_ROW_Y:   shadow_cfg.row_y = data[ROW_W-1:0];
            REG_ROW_Z:   shadow_cfg.row_z = data[ROW_W-1:0];
            REG_SHIFT_X: shadow_cfg.shift_x = data[SHIFT_W-1:0];
            REG_SHIFT_Y: shadow_cfg.shift_y = data[SHIFT_W-1:0];
            REG_SHIFT_Z: shadow_cfg.shift_z = data[SHIFT_W-1:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // offer one point request, optionally after a random gap; valid stays
    // high on return so back-to-back requests are offered without a gap
    task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic [CW-1:0] z, input logic last,
                              input logic typed, input point_out_t want);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_x <= x;
        s_in_y <= y;
        s_in_z <= z;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
        if (typed) begin
            owed_points.push_back(want);
        end else begin
            owed_points.push_back(transform_point(x, y, z, last));
        end
    endtask

    // stop offering and wait for every owed point to come out
    task automatic drain();
        s_valid <= 1'b0;
        while (owed_points.size() != 0) @(posedge aclk);
    endtask

    // receiver: check each accepted result, then pick the next ready
    always @(posedge aclk) begin
        point_out_t w;
        if (aresetn && m_valid && m_ready) begin
            if (owed_points.size() == 0) begin
                $error("result with no point request pending");
                fail_count++;
            end else begin
                w = owed_points.pop_front();
                if (m_out_x !== w.x) begin
                    $error("out_x: expected %h, got %h", w.x, m_out_x);
                    fail_count++;
                end
                if (m_out_y !== w.y) begin
                    $error("out_y: expected %h, got %h", w.y, m_out_y);
                    fail_count++;
                end
                if (m_out_z !== w.z) begin
                    $error("out_z: expected %h, got %h", w.z, m_out_z);
                    fail_count++;
                end
                if (m_out_last !== w.last) begin
                    $error("out_last: expected %b, got %b", w.last, m_out_last);
                    fail_count++;
                end
                if (m_saturated !== w.sat) begin
                    $error("saturated: expected %b, got %b", w.sat, m_saturated);
                    fail_count++;
                end
            end
        end
        // long hold-off counted here, the sender keeps pushing meanwhile
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_request > 0) begin
            hold_left = hold_request - 1;
            hold_request = 0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        plan_row_t r;
        shadow_cfg.row_x = ROW_X_RST;
        shadow_cfg.row_y = ROW_Y_RST;
        shadow_cfg.row_z = ROW_Z_RST;
        shadow_cfg.shift_x = '0;
        shadow_cfg.shift_y = '0;
        shadow_cfg.shift_z = '0;

        // identity after reset: points come back unchanged
        plan_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
                   1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        plan_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1,
                   1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
        plan_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0,
                   1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        plan_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 1'b1,
                   1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 1'b0);

        // full-scale coefficients, junk in the unused upper bits
        plan_cfg(REG_ROW_X, 64'hDEAD_8000_8000_8000);
        plan_cfg(REG_ROW_Y, 64'hFFFF_7FFF_7FFF_7FFF);
        plan_cfg(REG_ROW_Z, 64'hBEEF_0000_0000_0000);
        plan_cfg(REG_SHIFT_Z, 64'hFFFF_FFFF_7FFF_FFFF);
        // overflow both ways on x and y, z sits exactly on the top
        plan_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                   1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        plan_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0,
                   1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        plan_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
                   1'b1, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        plan_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b0,
                   1'b0, '0, '0, '0, 1'b0);

        // writes past the register map leave everything as it was
        plan_cfg(IDX_UNMAPPED_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_cfg(IDX_UNMAPPED_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
                   1'b1, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        plan_point(32'hFFF0_0000, 32'h0003_8000, 32'h7654_3210, 1'b0,
                   1'b0, '0, '0, '0, 1'b0);

        // rounding ties with tiny coefficients, translations at the extremes
        plan_cfg(REG_ROW_X, 64'h1234_0000_0000_0001);
        plan_cfg(REG_ROW_Y, 64'h0000_0000_0000_FFFF);
        plan_cfg(REG_ROW_Z, 64'h0000_7FFF_8000_4000);
        plan_cfg(REG_SHIFT_X, 64'hFFFF_FFFF_8000_0000);
        plan_cfg(REG_SHIFT_Y, 64'h0000_0000_7FFF_FFFF);
        plan_cfg(REG_SHIFT_Z, 64'h0000_0000_0001_0000);
        plan_point(32'h0000_2000, 32'h0000_0000, 32'h0000_0000, 1'b1,
                   1'b1, 32'h8000_0001, 32'h7FFF_FFFF, 32'h0001_2000, 1'b0);
        plan_point(32'hFFFF_E000, 32'h0000_0000, 32'h0000_0000, 1'b0,
                   1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_E000, 1'b1);
        plan_point(32'h0000_1FFF, 32'h0000_0000, 32'h0000_0000, 1'b0,
                   1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_1FFF, 1'b0);
        plan_point(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                   1'b0, '0, '0, '0, 1'b0);
        plan_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b0,
                   1'b0, '0, '0, '0, 1'b0);

        // hold reset at the start, then release
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part under the first idling mix
        send_idle_pct = 30;
        recv_idle_pct = 65;
        foreach (directed_plan[i]) begin
            r = directed_plan[i];
            if (r.is_cfg) begin
                drain();
                write_reg(r.idx, r.data);
            end else begin
                send_point(r.x, r.y, r.z, r.last, r.typed, r.want);
            end
        end

        // random part: a fresh setting per block, idling mix per third
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            drain();
            for (int g = REG_ROW_X; g <= REG_SHIFT_Z; g++) begin
                if (g <= REG_ROW_Z) begin
                    write_reg(CFG_IDX_W'(g), {16'($urandom()), pick_coef(),
                                              pick_coef(), pick_coef()});
                end else begin
                    write_reg(CFG_IDX_W'(g), {$urandom(), pick_fixed()});
                end
            end
            if (b < NUM_BLOCKS / 3) begin
                send_idle_pct = 30;
                recv_idle_pct = 65;
            end else if (b < 2 * NUM_BLOCKS / 3) begin
                send_idle_pct = 65;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // start of the no-idle third: receiver stalls, pipeline backs up
            if (b == 2 * NUM_BLOCKS / 3) begin
                hold_request = HOLD_OFF;
            end
            for (int k = 0; k < BLOCK_LEN; k++) begin
                send_point(pick_fixed(), pick_fixed(), pick_fixed(),
                           1'($urandom()), 1'b0, '0);
            end
        end

        // everything out, then a quiet stretch to catch stray results
        drain();
        repeat (PIPE_DEPTH * 4) @(posedge aclk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
